// ----- rtl/msfk_pkg.sv -----
package msfk_pkg;
	localparam int MAX_POINTS = 256;
	localparam int FEAT_SLOTS = 8;
	localparam int VALUE_BITS = 16;
	localparam int DIST_W = 40;
	localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};
	localparam logic CMD_POINT = 1'b0;
	localparam logic CMD_SEED  = 1'b1;
	localparam logic [2:0] REG_WINDOW   = 3'd0;
	localparam logic [2:0] REG_CONVERGE = 3'd1;
	localparam logic [2:0] REG_FEATURES = 3'd2;
	localparam logic [2:0] REG_POINTS   = 3'd3;
	localparam logic [2:0] REG_CAP      = 3'd4;
	localparam logic STATUS_CONVERGED = 1'b0;
	localparam logic STATUS_CAP       = 1'b1;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_START = 9'b000000010,
		ST_RD    = 9'b000000100,
		ST_ACC   = 9'b000001000,
		ST_PTEND = 9'b000010000,
		ST_DIV   = 9'b000100000,
		ST_CONV  = 9'b001000000,
		ST_DECIDE = 9'b010000000,
		ST_EMIT  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;
endpackage

// ----- rtl/mean_shift_flat_kernel_core.sv -----
// Mean-shift clustering core, flat kernel, fixed point.
// Input channel (in_valid/in_stall): cmd 0 writes one feature of a data point
// into the point store, one item per cycle. cmd 1 writes one seed feature;
// with last set it starts a run and the input stalls until the run's
// results are all delivered.
// A pass reads every point feature by feature from the single-port-read
// point RAM, then runs one serial division per feature and a convergence
// check over the features; if no point lies in the window, the window
// doubles instead. A run repeats passes, bounded by iteration_cap.
// Output channel (out_valid/out_stall): feature_count items, one per cycle
// when not stalled; the output register holds while out_stall is high.
// The input opens again in the cycle after the final item is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them while idle, which the block itself does not enforce.
// Reset clears the centre and control state; the point store is undefined
// until written.
module mean_shift_flat_kernel_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [39:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  point_index,
	input  logic [2:0]  feature_index,
	input  logic signed [msfk_pkg::VALUE_BITS-1:0] value,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  out_feature,
	output logic signed [msfk_pkg::VALUE_BITS-1:0] out_value,
	output logic        out_last,
	output logic        status,
	output logic [15:0] iterations
);
	import msfk_pkg::*;
	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int FW = (FEAT_SLOTS > 1) ? $clog2(FEAT_SLOTS) : 1;
	localparam int AW = $clog2(MAX_POINTS * FEAT_SLOTS) > 0 ?
		$clog2(MAX_POINTS * FEAT_SLOTS) : 1;
	localparam int SW = VALUE_BITS + PW + 1;
	localparam int DV = VALUE_BITS + 1;
	localparam int CNW = PW + 1;

	logic [39:0] window_limit_q;
	logic [31:0] converge_limit_q;
	logic [3:0]  feature_count_q;
	logic [8:0]  point_count_q;
	logic [15:0] iteration_cap_q;

	logic signed [VALUE_BITS-1:0] centre_q [FEAT_SLOTS];
	logic signed [VALUE_BITS-1:0] prev_q [FEAT_SLOTS];
	logic signed [SW-1:0] sums_q [FEAT_SLOTS];
	logic signed [VALUE_BITS-1:0] pt_q [FEAT_SLOTS];
	logic [CNW-1:0] inside_q;
	logic [39:0] window_q;
	logic [15:0] iter_q;
	logic        status_q;

	state_t state_q;
	logic [FW:0] fc;
	logic [CNW-1:0] pc;
	logic [15:0] cap;
	logic [CNW-1:0] p_q;
	logic [FW:0] f_q;
	logic [FW:0] frd_q;
	logic [40:0] acc_q;
	logic        sat_q;

	always_comb begin
		fc = (feature_count_q == 4'd0) ? (FW+1)'(1) :
			(32'(feature_count_q) > FEAT_SLOTS) ? (FW+1)'(FEAT_SLOTS) :
			(FW+1)'(feature_count_q);
		pc = (32'(point_count_q) > MAX_POINTS) ? CNW'(MAX_POINTS) : CNW'(point_count_q);
		cap = (iteration_cap_q == 16'd0) ? 16'd1 : iteration_cap_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_limit_q <= 40'd655360;
			converge_limit_q <= 32'd655;
			feature_count_q <= 4'd4;
			point_count_q <= 9'd150;
			iteration_cap_q <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW:   window_limit_q <= cfg_data;
				REG_CONVERGE: converge_limit_q <= cfg_data[31:0];
				REG_FEATURES: feature_count_q <= cfg_data[3:0];
				REG_POINTS:   point_count_q <= cfg_data[8:0];
				REG_CAP:      iteration_cap_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic in_acc;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [VALUE_BITS-1:0] ram_rdata;
	assign ram_we = in_acc && cmd == CMD_POINT && 32'(point_index) < MAX_POINTS &&
		32'(feature_index) < FEAT_SLOTS;
	assign ram_waddr = AW'(32'(point_index) * FEAT_SLOTS + 32'(feature_index));
	assign ram_raddr = AW'(32'(p_q) * FEAT_SLOTS + 32'(f_q));

	msfk_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_POINTS * FEAT_SLOTS)) u_store (
		.clk(clk), .we(ram_we), .waddr(ram_waddr),
		.wdata(value), .raddr(ram_raddr), .rdata(ram_rdata)
	);

	// distance term of returning feature
	logic signed [VALUE_BITS:0] dd;
	logic [VALUE_BITS:0] ad;
	logic [2*VALUE_BITS+1:0] sq;
	assign dd = {centre_q[frd_q[FW-1:0]][VALUE_BITS-1], centre_q[frd_q[FW-1:0]]} -
		{ram_rdata[VALUE_BITS-1], ram_rdata};
	assign ad = dd[VALUE_BITS] ? DV'(0) - dd : dd;
	assign sq = ad * ad;

	function automatic logic [40:0] add_sat(logic [40:0] a, logic [2*VALUE_BITS+1:0] b,
		logic big);
		logic [63:0] s;
		s = 64'(a) + 64'(b);
		if (big || s > 64'(DIST_SAT)) return {1'b0, DIST_SAT};
		return s[40:0];
	endfunction

	// division
	div_ctl_t dctl;
	logic dstart;
	logic [SW-1:0] dnum;
	logic [SW-1:0] dquo;
	logic ddone;
	logic [SW-1:0] mag;
	logic signed [SW-1:0] cur_sum;
	assign cur_sum = sums_q[f_q[FW-1:0]];
	assign mag = cur_sum[SW-1] ? SW'(0) - cur_sum : cur_sum;
	assign dnum = mag + SW'(inside_q >> 1);
	assign dctl.start = dstart;
	assign dctl.busy = 1'b0;

	msfk_div #(.NW(SW), .DW(CNW)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .num(dnum),
		.den(inside_q), .quo(dquo), .done(ddone)
	);
	logic div_wait_q;

	logic big_d;
	assign big_d = (32'(ad) >= (1 << 21));

	logic [2*VALUE_BITS+1:0] csq;
	logic signed [VALUE_BITS:0] cd;
	logic [VALUE_BITS:0] cad;
	assign cd = {prev_q[f_q[FW-1:0]][VALUE_BITS-1], prev_q[f_q[FW-1:0]]} -
		{centre_q[f_q[FW-1:0]][VALUE_BITS-1], centre_q[f_q[FW-1:0]]};
	assign cad = cd[VALUE_BITS] ? DV'(0) - cd : cd;
	assign csq = cad * cad;

	logic out_fire;
	assign out_fire = out_valid && !out_stall;
	assign dstart = (state_q == ST_DIV) && !div_wait_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < FEAT_SLOTS; i++) begin
				centre_q[i] <= '0;
				prev_q[i] <= '0;
				sums_q[i] <= '0;
				pt_q[i] <= '0;
			end
			p_q <= '0; f_q <= '0; frd_q <= '0; acc_q <= '0;
			iter_q <= '0; window_q <= '0; inside_q <= '0; status_q <= 1'b0;
			div_wait_q <= 1'b0; out_valid <= 1'b0; sat_q <= 1'b0;
			out_feature <= '0; out_value <= '0; out_last <= 1'b0;
			status <= 1'b0; iterations <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && cmd == CMD_SEED) begin
						if (32'(feature_index) < FEAT_SLOTS)
							centre_q[FW'(feature_index)] <= value;
						if (last) begin
							state_q <= ST_START;
							window_q <= window_limit_q;
							iter_q <= '0;
						end
					end
				end
				ST_START: begin
					iter_q <= iter_q + 1'b1;
					inside_q <= '0;
					for (int i = 0; i < FEAT_SLOTS; i++) sums_q[i] <= '0;
					p_q <= '0; f_q <= '0;
					acc_q <= '0; sat_q <= 1'b0;
					state_q <= (pc == '0) ? ST_DECIDE : ST_RD;
				end
				ST_RD: begin
					frd_q <= f_q;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					pt_q[frd_q[FW-1:0]] <= ram_rdata;
					acc_q <= add_sat(acc_q, sq, big_d || sat_q);
					if (big_d) sat_q <= 1'b1;
					if (frd_q + 1'b1 == fc) begin
						state_q <= ST_PTEND;
					end else begin
						f_q <= frd_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_PTEND: begin
					if (acc_q <= {1'b0, window_q}) begin
						inside_q <= inside_q + 1'b1;
						for (int i = 0; i < FEAT_SLOTS; i++)
							if (32'(i) < 32'(fc))
								sums_q[i] <= sums_q[i] + SW'(pt_q[i]);
					end
					acc_q <= '0; sat_q <= 1'b0; f_q <= '0;
					if (p_q + 1'b1 == pc) begin
						state_q <= ST_DECIDE;
					end else begin
						p_q <= p_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_DECIDE: begin
					f_q <= '0;
					if (inside_q == '0) begin
						window_q <= (window_q > (DIST_SAT >> 1)) ? DIST_SAT : window_q << 1;
						if (iter_q >= cap) begin
							status_q <= STATUS_CAP;
							state_q <= ST_EMIT;
						end else state_q <= ST_START;
					end else begin
						div_wait_q <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!div_wait_q) div_wait_q <= 1'b1;
					else if (ddone) begin
						div_wait_q <= 1'b0;
						prev_q[f_q[FW-1:0]] <= centre_q[f_q[FW-1:0]];
						centre_q[f_q[FW-1:0]] <= cur_sum[SW-1] ?
							VALUE_BITS'(SW'(0) - dquo) : VALUE_BITS'(dquo);
						if (f_q + 1'b1 == fc) begin
							f_q <= '0; acc_q <= '0; sat_q <= 1'b0;
							state_q <= ST_CONV;
						end else f_q <= f_q + 1'b1;
					end
				end
				ST_CONV: begin
					acc_q <= add_sat(acc_q, csq, sat_q || 32'(cad) >= (1 << 21));
					if (32'(cad) >= (1 << 21)) sat_q <= 1'b1;
					if (f_q + 1'b1 == fc) begin
						f_q <= '0;
						state_q <= ST_EMIT;
						if (iter_q > 16'd1 &&
							add_sat(acc_q, csq, sat_q || 32'(cad) >= (1 << 21)) <=
							41'(converge_limit_q)) begin
							status_q <= STATUS_CONVERGED;
						end else if (iter_q >= cap) begin
							status_q <= STATUS_CAP;
						end else state_q <= ST_START;
					end else f_q <= f_q + 1'b1;
				end
				ST_EMIT: begin
					if (!out_valid || out_fire) begin
						if (out_fire && out_last) begin
							out_valid <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							out_valid <= 1'b1;
							out_feature <= 3'(f_q);
							out_value <= centre_q[f_q[FW-1:0]];
							out_last <= (f_q + 1'b1 == fc);
							status <= status_q;
							iterations <= iter_q;
							f_q <= f_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	ap_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("input open while busy");
	ap_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == ST_EMIT)) else $error("output outside emit");
	ap_iter_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (iterations <= cap)) else $error("iterations above cap");
endmodule

// ----- rtl/msfk_ram.sv -----
module msfk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/msfk_div.sv -----
module msfk_div #(
	parameter int NW = 32,
	parameter int DW = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  msfk_pkg::div_ctl_t ctl,
	input  logic [NW-1:0]     num,
	input  logic [DW-1:0]     den,
	output logic [NW-1:0]     quo,
	output logic              done
);
	import msfk_pkg::*;
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [DW:0]   trial;

	assign trial = {r_q[DW-1:0], q_q[NW-1]} - {1'b0, d_q};
	assign quo = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start && !ctl.busy) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && !ctl.busy) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (run_q) begin
			if (!trial[DW]) begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[DW-1:0], q_q[NW-1]};
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule
